// ----- rtl/dts_pkg.sv -----
// Package for the deadline task scheduler: function and status codes.
// No dependencies.
package dts_pkg;
	typedef enum logic [2:0] {
		FN_POLL   = 3'd0,
		FN_ONCE   = 3'd1,
		FN_REPEAT = 3'd2,
		FN_CANCEL = 3'd3,
		FN_DONE   = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_NOTHING   = 3'd0,
		ST_DISPATCH  = 3'd1,
		ST_SCHEDULED = 3'd2,
		ST_FULL      = 3'd3,
		ST_CANCELLED = 3'd4,
		ST_NOTFOUND  = 3'd5,
		ST_DONE      = 3'd6
	} status_t;

	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
endpackage

// ----- rtl/dts_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module dts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/dts_cmp.sv -----
// Shared compare unit: wrap-aware earlier test, elapsed test and id equality.
// Depends on dts_pkg.
module dts_cmp
	import dts_pkg::*;
(
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] now_ms,
	output logic        earlier,
	output logic        elapsed,
	output logic        equal
);
	logic wrap_zone, late_a, late_b;
	logic [31:0] diff;

	always_comb begin
		wrap_zone = now_ms > HALF_RANGE;
		late_a = wrap_zone && a <= HALF_RANGE;
		late_b = wrap_zone && b <= HALF_RANGE;
		earlier = (late_a != late_b) ? !late_a : (a < b);
		diff = now_ms - a;
		elapsed = diff <= HALF_RANGE;
		equal = a == b;
	end
endmodule

// ----- rtl/deadline_task_scheduler.sv -----
// Top level of the deadline task scheduler: sequencer, slot RAMs, compare unit.
// Depends on dts_pkg, dts_ram and dts_cmp.
//
// Channel  Direction  tdata fields (low bit up)
// s_axis   in         func[2:0], now_ms, first_delay, period, target_id (+5 pad)
// m_axis   out        status[2:0], task_id, running_id (+5 pad)
//
// A poll or cancel sweeps the slots one a cycle through the shared compare unit.
// A due task found by a poll is then read out, and a cancel checks the running
// task before it sweeps. Schedule, done and a cancel of the running task work on
// one slot without a sweep; an item with nothing to do goes straight to the result.
// Reset clears the used bits, the id counter and the running slot at once.
// s_axis_tready is low from acceptance until the result has been taken.
module deadline_task_scheduler
	import dts_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // func, now_ms, first_delay, period, target_id
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // status, task_id, running_id
);
	localparam int SW = $clog2(SLOTS);

	typedef enum logic [2:0] {IDLE, SCAN, WAIT, FIN, WRITE, OUT} state_t;

	state_t state_q;
	logic [2:0]  func_q;
	logic [31:0] now_q, first_q, per_q, target_q;
	logic [SLOTS-1:0] used_q;
	logic [31:0] next_id_q;
	logic        run_q;
	logic [SW-1:0] run_slot_q;
	logic [31:0] run_id_q;
	logic [SW:0] idx_q;
	logic [SW-1:0] pipe_s1;
	logic        pvalid_s1;
	logic        found_q;
	logic [SW-1:0] best_q;
	logic [31:0] best_dl_q;
	logic [2:0]  status_q;
	logic [31:0] tid_q;

	// RAM port
	logic          we;
	logic [SW-1:0] addr;
	logic [31:0]   wdl, wper, wid, rdl, rper, rid;
	logic [1:0]    wfl, rfl;  // repeat, cancelled

	dts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_dl (.clk, .we, .addr, .wdata(wdl), .rdata(rdl));
	dts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_per (.clk, .we, .addr, .wdata(wper), .rdata(rper));
	dts_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_id (.clk, .we, .addr, .wdata(wid), .rdata(rid));
	dts_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_fl (.clk, .we, .addr, .wdata(wfl), .rdata(rfl));

	logic c_earlier, c_elapsed, c_equal;
	logic [31:0] ca, cb;
	dts_cmp u_cmp (.a(ca), .b(cb), .now_ms(now_q), .earlier(c_earlier),
		.elapsed(c_elapsed), .equal(c_equal));

	logic [SW-1:0] free_slot;
	logic          any_free;
	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	logic scan_done;
	assign scan_done = idx_q == (SW+1)'(SLOTS);

	always_comb begin
		we = 1'b0;
		wdl = rdl; wper = rper; wid = rid; wfl = rfl;
		addr = idx_q[SW-1:0];
		ca = rdl;
		cb = best_dl_q;
		if (state_q == SCAN && func_q == FN_CANCEL) begin
			ca = rid;
			cb = target_q;
		end else if (state_q == SCAN && !pvalid_s1) begin
			// The elapsed test reuses the compare unit with a = best deadline.
			ca = best_dl_q;
		end else if (state_q == FIN) begin
			cb = now_q;
		end
		if (state_q == WAIT || state_q == FIN) addr = best_q;
		if (state_q == WRITE) begin
			addr = best_q;
			we = 1'b1;
			if (func_q == FN_ONCE || func_q == FN_REPEAT) begin
				wdl = now_q + first_q;
				wper = (func_q == FN_REPEAT) ? per_q : 32'd0;
				wfl = {func_q == FN_REPEAT, 1'b0};
				wid = tid_q;
			end else if (func_q == FN_CANCEL) begin
				wfl = {rfl[1], 1'b1};
			end else begin
				wdl = now_q + rper;
			end
		end
	end

	logic best_elapsed;
	assign best_elapsed = c_elapsed;

	logic [31:0] nid;
	assign nid = (next_id_q + 32'd1 == 32'd0) ? 32'd1 : next_id_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			used_q <= '0;
			next_id_q <= '0;
			run_q <= 1'b0;
			run_slot_q <= '0;
			run_id_q <= '0;
			pvalid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (s_axis_tvalid) begin
					func_q <= s_axis_tdata[2:0];
					now_q <= s_axis_tdata[34:3];
					first_q <= s_axis_tdata[66:35];
					per_q <= s_axis_tdata[98:67];
					target_q <= s_axis_tdata[130:99];
					status_q <= ST_NOTHING;
					tid_q <= '0;
					idx_q <= '0;
					found_q <= 1'b0;
					pvalid_s1 <= 1'b0;
					unique case (s_axis_tdata[2:0])
						FN_POLL: state_q <= run_q ? OUT : SCAN;
						FN_ONCE, FN_REPEAT: begin
							if (any_free) begin
								best_q <= free_slot;
								state_q <= WRITE;
							end else begin
								status_q <= ST_FULL;
								state_q <= OUT;
							end
						end
						FN_CANCEL: begin
							status_q <= ST_NOTFOUND;
							if (s_axis_tdata[130:99] == 32'd0) state_q <= OUT;
							else if (run_q) begin
								best_q <= run_slot_q;
								state_q <= WAIT;
							end else state_q <= SCAN;
						end
						FN_DONE: if (run_q) begin
							best_q <= run_slot_q;
							state_q <= WAIT;
						end else state_q <= OUT;
						default: state_q <= OUT;
					endcase
				end
				SCAN: begin
					// RAM data for pipe_s1 arrives in the cycle after its address was applied.
					if (!scan_done) idx_q <= idx_q + 1'b1;
					pipe_s1 <= idx_q[SW-1:0];
					pvalid_s1 <= !scan_done;
					if (pvalid_s1 && used_q[pipe_s1] && !(run_q && run_slot_q == pipe_s1)) begin
						if (func_q == FN_POLL) begin
							if (!found_q || c_earlier) begin
								found_q <= 1'b1;
								best_q <= pipe_s1;
								best_dl_q <= rdl;
							end
						end else if (!found_q && !rfl[0] && c_equal) begin
							found_q <= 1'b1;
							best_q <= pipe_s1;
						end
					end
					if (scan_done && !pvalid_s1) begin
						if (func_q == FN_POLL && found_q && best_elapsed) state_q <= WAIT;
						else if (func_q == FN_CANCEL && found_q) begin
							used_q[best_q] <= 1'b0;
							status_q <= ST_CANCELLED;
							state_q <= OUT;
						end else state_q <= OUT;
					end
				end
				WAIT: state_q <= FIN;
				FIN: begin
					state_q <= OUT;
					if (func_q == FN_POLL) begin
						if (rfl[0]) used_q[best_q] <= 1'b0;
						else begin
							run_q <= 1'b1;
							run_slot_q <= best_q;
							run_id_q <= rid;
							status_q <= ST_DISPATCH;
							tid_q <= rid;
						end
					end else if (func_q == FN_CANCEL) begin
						if (!rfl[0] && rid == target_q) begin
							status_q <= ST_CANCELLED;
							state_q <= WRITE;
						end else begin
							idx_q <= '0;
							pvalid_s1 <= 1'b0;
							state_q <= SCAN;
						end
					end else begin
						status_q <= ST_DONE;
						run_q <= 1'b0;
						run_slot_q <= '0;
						run_id_q <= '0;
						if (rfl[1] && !rfl[0]) state_q <= WRITE;
						else used_q[best_q] <= 1'b0;
					end
				end
				WRITE: begin
					state_q <= OUT;
					if (func_q == FN_ONCE || func_q == FN_REPEAT) begin
						if (status_q != ST_SCHEDULED) begin
							next_id_q <= nid;
							tid_q <= nid;
							used_q[best_q] <= 1'b1;
							status_q <= ST_SCHEDULED;
							state_q <= WRITE;
						end
					end
				end
				OUT: if (m_axis_tready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == IDLE;
	assign m_axis_tvalid = state_q == OUT;
	assign m_axis_tdata = {5'd0, run_id_q, tid_q, status_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> run_id_q == 32'd0) else $error("running id without running task");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == ST_DISPATCH |-> run_q)
		else $error("dispatch without running task");
endmodule

// ----- bench/deadline_task_scheduler_tb.sv -----
// Testbench for deadline_task_scheduler: a directed table, a fill past capacity and drain, then random traffic.
// Results are checked against an internal model of the slot store; needs dts_pkg.
`timescale 1ns / 1ps

module deadline_task_scheduler_tb;
	import dts_pkg::*;

	localparam int NSLOT = 16;

	// Packed from the top bit down, so status lands in the low bits as on the bus.
	typedef struct packed {
		logic [31:0] running_id;
		logic [31:0] task_id;
		logic [2:0]  status;
	} sched_result_t;

	typedef struct {
		logic [2:0]  fn;
		logic [31:0] now;
		logic [31:0] delay;
		logic [31:0] per;
		logic [31:0] target;
		bit          typed;
		logic [2:0]  want_status;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;

	deadline_task_scheduler #(.SLOTS(NSLOT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Model of the slot store.
	bit          used_q[NSLOT];
	logic [31:0] deadline_q[NSLOT];
	logic [31:0] period_q[NSLOT];
	bit          repeat_q[NSLOT];
	bit          cancel_q[NSLOT];
	logic [31:0] ident_q[NSLOT];
	logic [31:0] last_ident;
	bit          busy;
	int          busy_slot;

	sched_result_t pending_results[$];
	logic [2:0]    pending_status_typed[$];
	int            errors = 0;
	bit            no_idle = 0;
	bit            hold_sink = 0;
	logic [31:0]   clock_ms = 0;

	function automatic bit sooner(logic [31:0] a, logic [31:0] b, logic [31:0] now);
		bit wz, la, lb;
		wz = now > HALF_RANGE;
		la = wz && a <= HALF_RANGE;
		lb = wz && b <= HALF_RANGE;
		if (la != lb) return !la;
		return a < b;
	endfunction

	function automatic sched_result_t predict_schedule(logic [2:0] fn, logic [31:0] now,
			logic [31:0] delay, logic [31:0] per, logic [31:0] target);
		sched_result_t r;
		int best;
		int s;
		r = '0;
		r.status = ST_NOTHING;
		case (fn)
			FN_POLL: if (!busy) begin
				best = -1;
				for (s = 0; s < NSLOT; s++)
					if (used_q[s] && (best < 0 || sooner(deadline_q[s], deadline_q[best], now)))
						best = s;
				if (best >= 0 && (now - deadline_q[best]) <= HALF_RANGE) begin
					if (cancel_q[best]) used_q[best] = 0;
					else begin
						busy = 1;
						busy_slot = best;
						r.status = ST_DISPATCH;
						r.task_id = ident_q[best];
					end
				end
			end
			FN_ONCE, FN_REPEAT: begin
				best = -1;
				for (s = 0; s < NSLOT; s++)
					if (!used_q[s] && best < 0) best = s;
				if (best < 0) r.status = ST_FULL;
				else begin
					last_ident = last_ident + 1;
					if (last_ident == 0) last_ident = 1;
					used_q[best] = 1;
					deadline_q[best] = now + delay;
					period_q[best] = (fn == FN_REPEAT) ? per : 32'd0;
					repeat_q[best] = (fn == FN_REPEAT);
					cancel_q[best] = 0;
					ident_q[best] = last_ident;
					r.status = ST_SCHEDULED;
					r.task_id = last_ident;
				end
			end
			FN_CANCEL: begin
				r.status = ST_NOTFOUND;
				if (target != 0) begin
					if (busy && !cancel_q[busy_slot] && ident_q[busy_slot] == target) begin
						cancel_q[busy_slot] = 1;
						r.status = ST_CANCELLED;
					end else begin
						for (s = 0; s < NSLOT; s++)
							if (r.status == ST_NOTFOUND && used_q[s] && !(busy && busy_slot == s)
									&& !cancel_q[s] && ident_q[s] == target) begin
								used_q[s] = 0;
								r.status = ST_CANCELLED;
							end
					end
				end
			end
			FN_DONE: if (busy) begin
				if (repeat_q[busy_slot] && !cancel_q[busy_slot])
					deadline_q[busy_slot] = now + period_q[busy_slot];
				else used_q[busy_slot] = 0;
				busy = 0;
				busy_slot = 0;
				r.status = ST_DONE;
			end
			default: ;
		endcase
		r.running_id = busy ? ident_q[busy_slot] : 32'd0;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Offer one transaction at a falling edge, after an optional random gap, and wait for its acceptance.
	// Valid stays up until the next falling edge, where the caller moves on.
	task automatic send_item(logic [2:0] fn, logic [31:0] now, logic [31:0] delay,
			logic [31:0] per, logic [31:0] target, bit typed, logic [2:0] want);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		pending_results.push_back(predict_schedule(fn, now, delay, per, target));
		pending_status_typed.push_back(typed ? want : 3'd7);
		s_axis_tdata <= {5'd0, target, per, delay, now, fn};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid after the last accepted transaction.
	task automatic idle_source();
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	// Receiver: random stall bursts, or a long hold when asked.
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (300) @(negedge clk);
				hold_sink = 0;
			end
			if (!no_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 0;
				gap = $urandom_range(1, 10);
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		sched_result_t got, want;
		logic [2:0] typed;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[66:0];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				typed = pending_status_typed.pop_front();
				if (typed != 3'd7 && typed != want.status) begin
					$display("%0t: table status expected %0d, actual %0d", $time, typed,
						want.status);
					errors++;
				end
				if (got.status != want.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.task_id != want.task_id) begin
					$display("%0t: task_id expected %h, actual %h", $time, want.task_id,
						got.task_id);
					errors++;
				end
				if (got.running_id != want.running_id) begin
					$display("%0t: running_id expected %h, actual %h", $time,
						want.running_id, got.running_id);
					errors++;
				end
			end
		end
	end

	task automatic random_item();
		int pick;
		logic [2:0] fn;
		logic [31:0] target;
		clock_ms = clock_ms + $urandom_range(0, 40);
		if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 30) fn = FN_POLL;
		else if (pick < 45) fn = FN_ONCE;
		else if (pick < 60) fn = FN_REPEAT;
		else if (pick < 75) fn = FN_CANCEL;
		else if (pick < 97) fn = FN_DONE;
		else fn = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 9) == 0) target = $urandom;
		else target = last_ident - $urandom_range(0, 20);
		send_item(fn, clock_ms,
			($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 60),
			($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 60),
			target, 0, 0);
	endtask

	initial begin
		stim_row_t table_rows[$];
		stim_row_t r;
		int i;
		for (i = 0; i < NSLOT; i++) begin
			used_q[i] = 0;
			deadline_q[i] = 0;
			period_q[i] = 0;
			repeat_q[i] = 0;
			cancel_q[i] = 0;
			ident_q[i] = 0;
		end
		last_ident = 0;
		busy = 0;
		busy_slot = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// fn, now, delay, period, target, typed, status
		table_rows = '{
			'{FN_POLL,   32'd0, 32'd0, 32'd0, 32'd0, 1, ST_NOTHING},
			'{FN_DONE,   32'd0, 32'd0, 32'd0, 32'd0, 1, ST_NOTHING},
			'{FN_CANCEL, 32'd0, 32'd0, 32'd0, 32'd0, 1, ST_NOTFOUND},
			'{FN_CANCEL, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_NOTFOUND},
			'{3'd5,      32'd0, 32'd0, 32'd0, 32'd0, 1, ST_NOTHING},
			'{3'd7,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
				ST_NOTHING},
			'{FN_ONCE,   32'd100, 32'd50, 32'hFFFF_FFFF, 32'd0, 1, ST_SCHEDULED},
			'{FN_REPEAT, 32'd100, 32'd10, 32'd20, 32'd0, 1, ST_SCHEDULED},
			'{FN_POLL,   32'd105, 32'd0, 32'd0, 32'd0, 1, ST_NOTHING},
			'{FN_POLL,   32'd110, 32'd0, 32'd0, 32'd0, 1, ST_DISPATCH},
			'{FN_POLL,   32'd200, 32'd0, 32'd0, 32'd0, 1, ST_NOTHING},
			'{FN_CANCEL, 32'd200, 32'd0, 32'd0, 32'd2, 1, ST_CANCELLED},
			'{FN_CANCEL, 32'd200, 32'd0, 32'd0, 32'd2, 1, ST_NOTFOUND},
			'{FN_DONE,   32'd200, 32'd0, 32'd0, 32'd0, 1, ST_DONE},
			'{FN_REPEAT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1,
				ST_SCHEDULED},
			'{FN_ONCE,   32'hFFFF_FFF0, 32'h20, 32'd0, 32'd0, 1, ST_SCHEDULED},
			'{FN_CANCEL, 32'd0, 32'd0, 32'd0, 32'd4, 0, 0},
			'{FN_POLL,   32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 0, 0},
			'{FN_DONE,   32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 0, 0},
			'{FN_POLL,   32'h8000_0001, 32'd0, 32'd0, 32'd0, 0, 0}
		};
		foreach (table_rows[k]) begin
			r = table_rows[k];
			send_item(r.fn, r.now, r.delay, r.per, r.target, r.typed, r.want_status);
		end

		// Fill the store past capacity while the receiver holds off.
		hold_sink = 1;
		for (i = 0; i < NSLOT + 2; i++)
			send_item(FN_ONCE, clock_ms, $urandom_range(0, 30), 0, 0, 0, 0);
		idle_source();
		wait (pending_results.size() == 0);
		for (i = 0; i < 2 * NSLOT; i++) begin
			send_item(FN_POLL, clock_ms + 100, 0, 0, 0, 0, 0);
			send_item(FN_DONE, clock_ms + 100, 0, 0, 0, 0, 0);
		end
		clock_ms = clock_ms + 100;

		for (i = 0; i < 420; i++) begin
			if (i == 200) begin
				idle_source();
				wait (pending_results.size() == 0);
			end
			if (i == 360) no_idle = 1;
			random_item();
		end

		// Id counter wrap is out of reach at 522 items, so only the low ids are used.
		idle_source();
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
